>>> rtl/onewire_rom_search_macros.svh
// Assertion macros shared by the onewire_rom_search RTL.
// Included by each file that carries concurrent assertions; no other dependencies.
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define OWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("onewire_rom_search: assertion failed");
// Next-cycle implication, checked outside reset.
`define OWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("onewire_rom_search: assertion failed");
`else
`define OWS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/ows_pkg.sv
// Package for the onewire_rom_search block: result kinds, item and result types, sizes.
// No dependencies; imported by every module of the block.
package ows_pkg;

	localparam int ID_BITS_DEF = 64;
	localparam int FAMILY_BITS = 8;
	localparam int OUTQ_DEPTH  = 4;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FOUND = 2'd2,
		KIND_FAIL  = 2'd3
	} kind_t;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_BITS  = 1'b1;

	typedef struct packed {
		logic func;
		logic restart;
		logic presence;
		logic id_bit;
		logic comp_bit;
	} item_t;

	typedef struct packed {
		kind_t kind;
		logic  write_bit;
		logic  last_device;
		logic  last;
	} res_t;

endpackage

>>> rtl/ows_core.sv
// Search state registers and the per-transaction decision logic.
// Depends on ows_pkg and onewire_rom_search_macros.svh.
`include "onewire_rom_search_macros.svh"

module ows_core #(
	parameter int ID_BITS = ows_pkg::ID_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ows_pkg::item_t      item,
	output ows_pkg::res_t       res0,
	output ows_pkg::res_t       res1,
	output logic                two,
	output logic [ID_BITS-1:0]  rom1
);
	import ows_pkg::*;

	localparam int POS_W = $clog2(ID_BITS + 2);
	localparam int IDX_W = $clog2(ID_BITS);

	logic [POS_W-1:0]   ld_q, lzp_q, pos_q;
	logic               ldf_q, in_pass_q;
	logic [ID_BITS-1:0] work_q, prev_q;

	logic [POS_W-1:0]   ld_d, lzp_d, pos_d;
	logic               ldf_d, in_pass_d;
	logic [ID_BITS-1:0] work_d, prev_d;

	logic [POS_W-1:0]   pos_m1, lzp_new;
	logic [IDX_W-1:0]   idx;
	logic               dir, end_of_pass, rs_ldf;
	logic [ID_BITS-1:0] work_new;

	assign pos_m1      = pos_q - POS_W'(1);
	assign idx         = pos_m1[IDX_W-1:0];
	assign end_of_pass = (pos_q == POS_W'(ID_BITS));
	assign rs_ldf      = item.restart ? 1'b0 : ldf_q;

	always_comb begin
		if (item.id_bit != item.comp_bit) begin
			dir = item.id_bit;
		end else if (pos_q < ld_q) begin
			dir = prev_q[idx];
		end else begin
			dir = (pos_q == ld_q);
		end
		lzp_new = ((item.id_bit == item.comp_bit) && !dir) ? pos_q : lzp_q;
		work_new = work_q;
		work_new[idx] = dir;
	end

	always_comb begin
		ld_d      = ld_q;
		ldf_d     = ldf_q;
		lzp_d     = lzp_q;
		pos_d     = pos_q;
		work_d    = work_q;
		prev_d    = prev_q;
		in_pass_d = in_pass_q;
		res0      = '{kind: KIND_FAIL, write_bit: 1'b0, last_device: 1'b0, last: 1'b1};
		res1      = '{kind: KIND_FAIL, write_bit: 1'b0, last_device: 1'b0, last: 1'b1};
		two       = 1'b0;
		rom1      = '0;
		if (item.func == FUNC_START) begin
			if (rs_ldf || !item.presence) begin
				ld_d      = '0;
				ldf_d     = 1'b0;
				in_pass_d = 1'b0;
			end else begin
				ld_d      = item.restart ? '0 : ld_q;
				ldf_d     = 1'b0;
				in_pass_d = 1'b1;
				pos_d     = POS_W'(1);
				lzp_d     = '0;
				work_d    = '0;
				res0.kind = KIND_CMD;
			end
		end else if (in_pass_q) begin
			if (item.id_bit && item.comp_bit) begin
				ld_d      = '0;
				ldf_d     = 1'b0;
				in_pass_d = 1'b0;
			end else begin
				lzp_d          = lzp_new;
				work_d         = work_new;
				pos_d          = pos_q + POS_W'(1);
				res0.kind      = KIND_WRITE;
				res0.write_bit = dir;
				if (end_of_pass) begin
					res0.last = 1'b0;
					two       = 1'b1;
					in_pass_d = 1'b0;
					prev_d    = work_new;
					if (work_new[FAMILY_BITS-1:0] == '0) begin
						ld_d  = '0;
						ldf_d = 1'b0;
					end else begin
						ld_d             = lzp_new;
						ldf_d            = (lzp_new == '0);
						res1.kind        = KIND_FOUND;
						res1.last_device = (lzp_new == '0);
						rom1             = work_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q      <= '0;
			ldf_q     <= 1'b0;
			lzp_q     <= '0;
			pos_q     <= POS_W'(1);
			work_q    <= '0;
			prev_q    <= '0;
			in_pass_q <= 1'b0;
		end else if (fire) begin
			ld_q      <= ld_d;
			ldf_q     <= ldf_d;
			lzp_q     <= lzp_d;
			pos_q     <= pos_d;
			work_q    <= work_d;
			prev_q    <= prev_d;
			in_pass_q <= in_pass_d;
		end
	end

	`OWS_ASSERT_IMPL(a_pos_in_range, clk, arst_n, in_pass_q, (pos_q <= POS_W'(ID_BITS)) && (pos_q != '0))
	`OWS_ASSERT_NEXT(a_pass_ends, clk, arst_n, fire && two, !in_pass_q && (pos_q == POS_W'(ID_BITS + 1)))
	`OWS_ASSERT_NEXT(a_cmd_opens, clk, arst_n, fire && (res0.kind == KIND_CMD), in_pass_q && (pos_q == POS_W'(1)) && (work_q == '0))
	`OWS_ASSERT_IMPL(a_found_last_dev, clk, arst_n, two && (res1.kind == KIND_FOUND), res1.last_device == (ld_d == '0))

endmodule

>>> rtl/ows_outq.sv
// Result queue: takes one or two results per transaction, hands out one per cycle while out_ready is high.
// Depends on ows_pkg and onewire_rom_search_macros.svh.
`include "onewire_rom_search_macros.svh"

module ows_outq #(
	parameter int ID_BITS = ows_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               push_two,
	input  ows_pkg::res_t      res0,
	input  ows_pkg::res_t      res1,
	input  logic [ID_BITS-1:0] rom1,
	output logic               space_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output ows_pkg::res_t      head,
	output logic [ID_BITS-1:0] head_rom
);
	import ows_pkg::*;

	localparam int DEPTH = OUTQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t               ent_q [DEPTH];
	logic [ID_BITS-1:0] rom_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q, wr_p1;
	logic [CNT_W-1:0]   count_q, n_push;
	logic               pop;

	assign wr_p1     = wr_q + PTR_W'(1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign space_ok  = (count_q <= CNT_W'(DEPTH - 2));
	assign head      = ent_q[rd_q];
	assign head_rom  = rom_q[rd_q];
	assign n_push    = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : '0;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= res0;
			rom_q[wr_q] <= '0;
			if (push_two) begin
				ent_q[wr_p1] <= res1;
				rom_q[wr_p1] <= rom1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	`OWS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`OWS_ASSERT_IMPL(a_push_room, clk, arst_n, push, space_ok)

endmodule

>>> rtl/onewire_rom_search.sv
// Top level of the 1-Wire search-ROM decision engine.
// Depends on ows_pkg, ows_core and ows_outq.
//
// Input channel (in_valid/in_ready) carries one transaction per command: func = 0
// starts a search pass (restart, presence), func = 1 delivers one read bit pair
// (id_bit, comp_bit), least significant ROM bit first.
// Output channel (out_valid/out_ready) returns results: kind (send search command,
// write direction bit, device found, search failed), write_bit, rom_id, last_device,
// and last, which marks the final result of a transaction.
// Every transaction gives one result; the final bit pair of a pass gives two.
// The input stage registers each accepted transaction; its results are written into the
// result queue from there, and the first of them is offered at the queue head.
// Throughput: one transaction per cycle, limited only by the output port draining
// one result per cycle through a four-entry result queue.
// A stalled receiver fills the queue; the input stage then holds its transaction
// and in_ready drops until room for two results is free.
// Reset clears the search state (no pass open, no discrepancy) and empties the queue.
module onewire_rom_search #(
	parameter int ID_BITS = ows_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic               restart,
	input  logic               presence,
	input  logic               id_bit,
	input  logic               comp_bit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic               write_bit,
	output logic [ID_BITS-1:0] rom_id,
	output logic               last_device,
	output logic               last
);
	import ows_pkg::*;

	item_t              item_s1;
	logic               valid_s1;
	logic               fire, space_ok, two;
	res_t               res0, res1, head;
	logic [ID_BITS-1:0] rom1;

	assign fire     = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{func: func, restart: restart, presence: presence,
				id_bit: id_bit, comp_bit: comp_bit};
		end
	end

	ows_core #(
		.ID_BITS(ID_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.res0  (res0),
		.res1  (res1),
		.two   (two),
		.rom1  (rom1)
	);

	ows_outq #(
		.ID_BITS(ID_BITS)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.push_two (two),
		.res0     (res0),
		.res1     (res1),
		.rom1     (rom1),
		.space_ok (space_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head),
		.head_rom (rom_id)
	);

	assign kind        = head.kind;
	assign write_bit   = head.write_bit;
	assign last_device = head.last_device;
	assign last        = head.last;

endmodule

>>> sim/ows_checker.sv
// Scoreboard for onewire_rom_search: predicts the result transactions of every accepted
// input transaction and compares them, in order, with the output channel.
// Depends on ows_pkg; instantiated by tb_onewire_rom_search.
module ows_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           func,
	input  logic                           restart,
	input  logic                           presence,
	input  logic                           id_bit,
	input  logic                           comp_bit,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [1:0]                     kind,
	input  logic                           write_bit,
	input  logic [ows_pkg::ID_BITS_DEF-1:0] rom_id,
	input  logic                           last_device,
	input  logic                           last,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ows_pkg::*;

	typedef struct packed {
		kind_t                  kind;
		logic                   write_bit;
		logic [ID_BITS_DEF-1:0] rom;
		logic                   last_dev;
		logic                   last;
	} search_result_t;

	logic [6:0]             last_disc;
	logic [6:0]             zero_pos;
	logic [6:0]             bit_pos;
	logic                   dev_done;
	logic                   in_pass;
	logic [ID_BITS_DEF-1:0] work_rom;
	logic [ID_BITS_DEF-1:0] prev_rom;
	search_result_t         expected_q[$];
	int                     errs;

	function automatic void queue_result(kind_t k, logic w, logic [ID_BITS_DEF-1:0] rom,
			logic ld, logic lst);
		expected_q.push_back('{kind: k, write_bit: w, rom: rom, last_dev: ld, last: lst});
	endfunction

	function automatic void drop_search();
		last_disc = '0;
		dev_done  = 1'b0;
		in_pass   = 1'b0;
	endfunction

	task automatic search_step(input logic f, input logic r, input logic p,
			input logic a, input logic b);
		logic       dir;
		logic [5:0] idx;
		if (f == FUNC_START) begin
			if (r) begin
				last_disc = '0;
				dev_done  = 1'b0;
			end
			if (dev_done || !p) begin
				drop_search();
				queue_result(KIND_FAIL, 1'b0, '0, 1'b0, 1'b1);
			end else begin
				in_pass  = 1'b1;
				bit_pos  = 7'd1;
				zero_pos = '0;
				work_rom = '0;
				queue_result(KIND_CMD, 1'b0, '0, 1'b0, 1'b1);
			end
		end else if (!in_pass) begin
			queue_result(KIND_FAIL, 1'b0, '0, 1'b0, 1'b1);
		end else if (a && b) begin
			drop_search();
			queue_result(KIND_FAIL, 1'b0, '0, 1'b0, 1'b1);
		end else begin
			idx = 6'(bit_pos - 7'd1);
			if (a != b) begin
				dir = a;
			end else begin
				if (bit_pos < last_disc)
					dir = prev_rom[idx];
				else
					dir = (bit_pos == last_disc);
				if (!dir)
					zero_pos = bit_pos;
			end
			work_rom[idx] = dir;
			bit_pos = bit_pos + 7'd1;
			if (bit_pos <= ID_BITS_DEF) begin
				queue_result(KIND_WRITE, dir, '0, 1'b0, 1'b1);
			end else begin
				queue_result(KIND_WRITE, dir, '0, 1'b0, 1'b0);
				in_pass  = 1'b0;
				prev_rom = work_rom;
				if (work_rom[FAMILY_BITS-1:0] == '0) begin
					drop_search();
					queue_result(KIND_FAIL, 1'b0, '0, 1'b0, 1'b1);
				end else begin
					last_disc = zero_pos;
					dev_done  = (zero_pos == '0);
					queue_result(KIND_FOUND, 1'b0, work_rom, dev_done, 1'b1);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		search_result_t want;
		if (!arst_n) begin
			last_disc = '0;
			zero_pos  = '0;
			bit_pos   = 7'd1;
			dev_done  = 1'b0;
			in_pass   = 1'b0;
			work_rom  = '0;
			prev_rom  = '0;
			errs      = 0;
			expected_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with nothing expected: kind %0d", kind);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						errs++;
					end
					if (write_bit !== want.write_bit) begin
						$error("write_bit: expected %0d, actual %0d", want.write_bit, write_bit);
						errs++;
					end
					if (rom_id !== want.rom) begin
						$error("rom_id: expected %016h, actual %016h", want.rom, rom_id);
						errs++;
					end
					if (last_device !== want.last_dev) begin
						$error("last_device: expected %0d, actual %0d", want.last_dev,
							last_device);
						errs++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				search_step(func, restart, presence, id_bit, comp_bit);
			mismatches  <= errs;
			outstanding <= expected_q.size();
		end
	end

endmodule

>>> sim/tb_onewire_rom_search.sv
// Testbench top for onewire_rom_search: directed and random search passes with random
// idling on both channels; checking is done by ows_checker. Depends on ows_pkg.
module tb_onewire_rom_search;
	timeunit 1ns;
	timeprecision 1ps;

	import ows_pkg::*;

	localparam int ITEM_COUNT     = 850;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int IDLE_PCT       = 14;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   func;
	logic                   restart;
	logic                   presence;
	logic                   id_bit;
	logic                   comp_bit;
	logic                   out_valid;
	logic                   out_ready;
	logic [1:0]             kind;
	logic                   write_bit;
	logic [ID_BITS_DEF-1:0] rom_id;
	logic                   last_device;
	logic                   last;
	int                     mismatches;
	int                     outstanding;
	int                     sent;

	onewire_rom_search DUT (.*);

	ows_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_op(input logic f, input logic r, input logic p,
			input logic a, input logic b);
		if (!(sent >= 400 && sent < 560) && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		restart    <= r;
		presence   <= p;
		id_bit     <= a;
		comp_bit   <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_pass();
		int   conflict_pct;
		int   cut;
		int   abort_at;
		logic zero_family;
		logic a;
		logic b;
		send_op(FUNC_START, $urandom_range(99) < 20, $urandom_range(99) < 92,
			1'($urandom_range(1)), 1'($urandom_range(1)));
		case ($urandom_range(3))
			0: conflict_pct = 0;
			1: conflict_pct = 3;
			2: conflict_pct = 12;
			default: conflict_pct = 35;
		endcase
		zero_family = ($urandom_range(99) < 8);
		cut = ($urandom_range(99) < 10) ? $urandom_range(1, ID_BITS_DEF - 1) : ID_BITS_DEF;
		abort_at = ($urandom_range(99) < 6) ? $urandom_range(0, ID_BITS_DEF - 1) : -1;
		for (int i = 0; i < cut; i++) begin
			if (i == abort_at) begin
				a = 1'b1;
				b = 1'b1;
			end else if (zero_family && i < FAMILY_BITS) begin
				a = 1'b0;
				b = 1'b1;
			end else if ($urandom_range(99) < conflict_pct) begin
				a = 1'b0;
				b = 1'b0;
			end else begin
				a = 1'($urandom_range(1));
				b = !a;
			end
			send_op(FUNC_BITS, 1'($urandom_range(1)), 1'($urandom_range(1)), a, b);
		end
		if ($urandom_range(99) < 15)
			send_op(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	initial begin
		int cyc;
		out_ready <= 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 600 && cyc < 900)
				out_ready <= 1'b0;
			else if (cyc >= 150 && cyc < 450)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		bit mid_drained;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= FUNC_START;
		restart    <= 1'b0;
		presence   <= 1'b0;
		id_bit     <= 1'b0;
		comp_bit   <= 1'b0;
		sent = 0;
		mid_drained = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b1, 1'b0);
		send_op(FUNC_START, 1'b0, 1'b0, 1'b0, 1'b0);
		send_op(FUNC_START, 1'b1, 1'b1, 1'b0, 1'b0);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b1, 1'b0);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b0, 1'b1);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b0, 1'b0);
		send_op(FUNC_BITS, 1'b1, 1'b1, 1'b0, 1'b0);
		send_op(FUNC_START, 1'b0, 1'b1, 1'b1, 1'b1);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b0, 1'b0);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b1, 1'b0);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b1, 1'b1);
		send_op(FUNC_BITS, 1'b0, 1'b0, 1'b0, 1'b1);
		send_op(FUNC_START, 1'b1, 1'b0, 1'b0, 1'b0);
		send_op(FUNC_START, 1'b1, 1'b1, 1'b0, 1'b0);
		send_op(FUNC_BITS, 1'b1, 1'b0, 1'b1, 1'b1);
		drain_results();

		while (sent < ITEM_COUNT) begin
			random_pass();
			if (!mid_drained && sent >= 600) begin
				drain_results();
				mid_drained = 1'b1;
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
